>>> hw/rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ATS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ats assertion failed");

// next-cycle implication, disabled during reset
`define ATS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ats assertion failed");

`endif

>>> hw/rtl/ats_pkg.sv
// types, codes and constants of the annealing tour swap engine
// no dependencies
package ats_pkg;

   localparam int MAX_CITIES     = 16;
   localparam int CITY_BITS      = 4;
   localparam int SLOTS          = MAX_CITIES - 1;
   localparam int SLOT_BITS      = 4;
   localparam int NUM_BITS       = 5;
   localparam int DIST_BITS      = 16;
   localparam int DIST_ADDR_BITS = 2 * CITY_BITS;
   localparam int COST_BITS      = 20;
   localparam int TEMP_BITS      = 40;
   localparam int TEMP_FRAC_BITS = 8;
   localparam int CF_BITS        = 16;
   localparam int RAND_BITS      = 16;
   localparam int X_FRAC         = 16;
   localparam int X_BITS         = 21;
   localparam int X_IDX_BITS     = 5;
   localparam int EXP_FRAC       = 30;
   localparam int R_BITS         = EXP_FRAC + 1;
   localparam int DIV_PRESHIFT   = X_FRAC + TEMP_FRAC_BITS - X_BITS;
   localparam int ALU_BITS       = TEMP_BITS + 1;
   localparam int ACTION_BITS    = 3;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [COST_BITS-1:0] COST_MAX = '1;
   localparam logic [TEMP_BITS-1:0] ONE_TEMP = TEMP_BITS'(1) << TEMP_FRAC_BITS;

   // request actions
   localparam logic [ACTION_BITS-1:0] ACT_WR_DIST = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_WR_SLOT = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_RESTART = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_PROPOSE = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_RD_SLOT = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_CITIES  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_CITY = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_TEMP  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COOLING     = 2'd3;

   typedef enum logic [2:0] {
      ALU_ADD_SAT,
      ALU_SUB_GE,
      ALU_DIV_STEP,
      ALU_MUL_EXP,
      ALU_MUL_COOL
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_TOUR,
      ST_WALK_DIST,
      ST_WALK_ACC,
      ST_COMPARE,
      ST_DIFF,
      ST_RANGE,
      ST_DIV,
      ST_EXP,
      ST_DECIDE,
      ST_TAKE,
      ST_COMMIT_A,
      ST_COMMIT_B,
      ST_REJECT,
      ST_COOL,
      ST_FINISH
   } state_type;

   // exp(-2^(j-16)) in Q0.30
   function automatic logic [EXP_FRAC-1:0] exp_coef(input logic [X_IDX_BITS-1:0] j);
      logic [EXP_FRAC-1:0] v;
      case (j)
         5'd0:    v = 30'd1073725440;
         5'd1:    v = 30'd1073709056;
         5'd2:    v = 30'd1073676290;
         5'd3:    v = 30'd1073610760;
         5'd4:    v = 30'd1073479712;
         5'd5:    v = 30'd1073217664;
         5'd6:    v = 30'd1072693760;
         5'd7:    v = 30'd1071646719;
         5'd8:    v = 30'd1069555701;
         5'd9:    v = 30'd1065385899;
         5'd10:   v = 30'd1057095000;
         5'd11:   v = 30'd1040706261;
         5'd12:   v = 30'd1008687096;
         5'd13:   v = 30'd947573834;
         5'd14:   v = 30'd836230973;
         5'd15:   v = 30'd651257337;
         5'd16:   v = 30'd395007542;
         5'd17:   v = 30'd145315154;
         5'd18:   v = 30'd19666268;
         5'd19:   v = 30'd360200;
         5'd20:   v = 30'd121;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/annealing_tour_swap_engine_top.sv
// annealing tour swap engine: sequencer, tour and distance memories, state
// depends on ats_pkg and ats_alu
//
// Requests enter on req_* (valid/stall) and each gives exactly one response
// on rsp_* (valid/stall). Registers are to be written on csr_* only while
// the block idles; the block itself does not enforce it. Distance and slot
// writes, reads and unknown actions go from idle straight to the finish state.
// A restart walks the tour: each edge reads the tour memory, then the distance
// memory, then adds, and the edge back to the source skips the tour read, as
// set by the single read port of each memory and the shared adder. A proposal
// adds to the walk a compare, up to 21 division steps and 21 exp steps on the
// shared unit, then the write-back and cooling where they apply.
// req_stall is high from acceptance until the sequencer returns to idle.
// The response sits in an output register; a stalled receiver holds it and
// the next request may be accepted, but its response waits for the register.
// Reset clears the registers to their reset values and the temperature to
// zero, so the block reports done until a restart. Distance and tour
// memories are not cleared and must be written before use.
module annealing_tour_swap_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ats_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [ats_pkg::CITY_BITS-1:0]       req_row_city,
   input  logic [ats_pkg::CITY_BITS-1:0]       req_col_city,
   input  logic [ats_pkg::DIST_BITS-1:0]       req_distance,
   input  logic [ats_pkg::SLOT_BITS-1:0]       req_slot,
   input  logic [ats_pkg::CITY_BITS-1:0]       req_city,
   input  logic [ats_pkg::SLOT_BITS-1:0]       req_other_slot,
   input  logic [ats_pkg::RAND_BITS-1:0]       req_random_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [ats_pkg::COST_BITS-1:0]       rsp_tour_cost,
   output logic                                rsp_done_res,
   output logic [ats_pkg::CITY_BITS-1:0]       rsp_city_out,
   input  logic                                csr_write,
   input  logic [ats_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ats_pkg::TEMP_BITS-1:0]       csr_wdata
);
   import ats_pkg::*;

   // configuration
   logic [NUM_BITS-1:0]     num_ff;
   logic [CITY_BITS-1:0]    src_ff;
   logic [TEMP_BITS-1:0]    start_temp_ff;
   logic [CF_BITS-1:0]      cf_ff;

   // memories
   logic [DIST_BITS-1:0]    dist_mem [0:MAX_CITIES*MAX_CITIES-1];
   logic [CITY_BITS-1:0]    tour_mem [0:SLOTS-1];
   logic [DIST_BITS-1:0]    dist_q_ff;
   logic [CITY_BITS-1:0]    tour_q_ff;
   logic [DIST_ADDR_BITS-1:0] dist_waddr;
   logic [DIST_ADDR_BITS-1:0] dist_raddr;
   logic                    dist_we;
   logic [SLOT_BITS-1:0]    tour_waddr;
   logic [SLOT_BITS-1:0]    tour_raddr;
   logic [CITY_BITS-1:0]    tour_wdata;
   logic                    tour_we;

   // sequencer and datapath
   state_type               state_ff, state_in;
   logic [ACTION_BITS-1:0]  action_ff;
   logic [SLOT_BITS-1:0]    slot_ff, other_ff, idx_ff, map_idx;
   logic                    swap_ff;
   logic [RAND_BITS-1:0]    rand_ff;
   logic [CITY_BITS-1:0]    at_ff, city_ff, city_slot_ff, city_other_ff, walk_city;
   logic [COST_BITS-1:0]    sum_ff, cost_ff;
   logic [TEMP_BITS-1:0]    temp_ff;
   logic [SLOT_BITS-1:0]    rej_ff, rej_inc;
   logic [ALU_BITS-1:0]     rem_ff;
   logic [X_BITS-1:0]       x_ff;
   logic [X_IDX_BITS-1:0]   bit_ff;
   logic [R_BITS-1:0]       r_ff;
   logic                    acc_ff;
   logic [SLOT_BITS-1:0]    len;
   logic                    req_take, propose_ok, out_free, last_edge;
   logic [RAND_BITS:0]      prob;

   // output register
   logic                    rsp_valid_ff, rsp_accepted_ff, rsp_done_ff;
   logic [COST_BITS-1:0]    rsp_cost_ff;
   logic [CITY_BITS-1:0]    rsp_city_ff;

   // shared unit
   alu_op_type              alu_op;
   logic [ALU_BITS-1:0]     alu_a, alu_b, alu_res;
   logic                    alu_flag;

   ats_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_res),
      .flag   (alu_flag)
   );

   // tour length, num_cities clamped to the legal range
   always_comb begin
      if (num_ff < NUM_BITS'(2)) begin
         len = SLOT_BITS'(1);
      end else if (num_ff > NUM_BITS'(MAX_CITIES)) begin
         len = SLOT_BITS'(SLOTS);
      end else begin
         len = SLOT_BITS'(num_ff - NUM_BITS'(1));
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign propose_ok = (temp_ff > ONE_TEMP) && (req_slot < len) && (req_other_slot < len);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_edge  = (idx_ff == len);
   assign rej_inc    = rej_ff + SLOT_BITS'(1);
   assign prob       = r_ff[EXP_FRAC -: RAND_BITS+1];

   // slot seen at walk step idx with the proposed swap applied
   always_comb begin
      map_idx = idx_ff;
      if (swap_ff && idx_ff == slot_ff) begin
         map_idx = other_ff;
      end else if (swap_ff && idx_ff == other_ff) begin
         map_idx = slot_ff;
      end
   end

   assign walk_city = last_edge ? src_ff : tour_q_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_action)
                  ACT_RESTART: state_in = ST_WALK_TOUR;
                  ACT_PROPOSE: state_in = propose_ok ? ST_WALK_TOUR : ST_FINISH;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_WALK_TOUR: state_in = ST_WALK_DIST;
         ST_WALK_DIST: state_in = ST_WALK_ACC;
         ST_WALK_ACC: begin
            if (last_edge) begin
               state_in = swap_ff ? ST_COMPARE : ST_FINISH;
            end else if (idx_ff + SLOT_BITS'(1) == len) begin
               state_in = ST_WALK_DIST;
            end else begin
               state_in = ST_WALK_TOUR;
            end
         end
         ST_COMPARE:  state_in = alu_flag ? ST_TAKE : ST_DIFF;
         ST_DIFF:     state_in = ST_RANGE;
         ST_RANGE:    state_in = alu_flag ? ST_REJECT : ST_DIV;
         ST_DIV:      state_in = (bit_ff == '0) ? ST_EXP : ST_DIV;
         ST_EXP:      state_in = (bit_ff == X_IDX_BITS'(X_BITS-1)) ? ST_DECIDE : ST_EXP;
         ST_DECIDE:   state_in = (prob > (RAND_BITS+1)'(rand_ff)) ? ST_TAKE : ST_REJECT;
         ST_TAKE:     state_in = ST_COMMIT_A;
         ST_COMMIT_A: state_in = ST_COMMIT_B;
         ST_COMMIT_B: state_in = ST_COOL;
         ST_REJECT:   state_in = (rej_inc >= len) ? ST_COOL : ST_FINISH;
         ST_COOL:     state_in = ST_FINISH;
         ST_FINISH:   state_in = out_free ? ST_IDLE : ST_FINISH;
         default:     state_in = ST_IDLE;
      endcase
   end

   // unit operands and memory ports
   always_comb begin
      alu_op     = ALU_ADD_SAT;
      alu_a      = ALU_BITS'(sum_ff);
      alu_b      = ALU_BITS'(dist_q_ff);
      dist_we    = 1'b0;
      dist_waddr = {req_row_city, req_col_city};
      dist_raddr = {at_ff, walk_city};
      tour_we    = 1'b0;
      tour_waddr = req_slot;
      tour_wdata = req_city;
      tour_raddr = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            tour_raddr = req_slot;
            dist_we    = req_take && (req_action == ACT_WR_DIST);
            tour_we    = req_take && (req_action == ACT_WR_SLOT)
                         && (req_slot < SLOT_BITS'(SLOTS));
         end
         ST_WALK_TOUR: tour_raddr = map_idx;
         ST_COMPARE: begin
            alu_op = ALU_SUB_GE;
            alu_a  = ALU_BITS'(cost_ff);
            alu_b  = ALU_BITS'(sum_ff);
         end
         ST_DIFF: begin
            alu_op = ALU_SUB_GE;
            alu_a  = ALU_BITS'(sum_ff);
            alu_b  = ALU_BITS'(cost_ff);
         end
         ST_RANGE: begin
            alu_op = ALU_SUB_GE;
            alu_a  = rem_ff;
            alu_b  = ALU_BITS'(temp_ff);
         end
         ST_DIV: begin
            alu_op = ALU_DIV_STEP;
            alu_a  = rem_ff;
            alu_b  = ALU_BITS'(temp_ff);
         end
         ST_EXP: begin
            alu_op = ALU_MUL_EXP;
            alu_a  = ALU_BITS'(r_ff);
            alu_b  = ALU_BITS'(exp_coef(bit_ff));
         end
         ST_COMMIT_A: begin
            tour_we    = 1'b1;
            tour_waddr = slot_ff;
            tour_wdata = city_slot_ff;
         end
         ST_COMMIT_B: begin
            tour_we    = 1'b1;
            tour_waddr = other_ff;
            tour_wdata = city_other_ff;
         end
         ST_COOL: begin
            alu_op = ALU_MUL_COOL;
            alu_a  = ALU_BITS'(temp_ff);
            alu_b  = ALU_BITS'(cf_ff);
         end
         default: begin
            alu_op = ALU_ADD_SAT;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= req_distance;
      end
      dist_q_ff <= dist_mem[dist_raddr];
   end

   always_ff @(posedge clock) begin
      if (tour_we) begin
         tour_mem[tour_waddr] <= tour_wdata;
      end
      tour_q_ff <= tour_mem[tour_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff        <= NUM_BITS'(MAX_CITIES);
         src_ff        <= '0;
         start_temp_ff <= '1;
         cf_ff         <= CF_BITS'(58982);
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_CITIES:  num_ff        <= csr_wdata[NUM_BITS-1:0];
            CSR_SOURCE_CITY: src_ff        <= csr_wdata[CITY_BITS-1:0];
            CSR_START_TEMP:  start_temp_ff <= csr_wdata;
            CSR_COOLING:     cf_ff         <= csr_wdata[CF_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cost_ff      <= '0;
         temp_ff      <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_WALK_ACC: begin
               if (last_edge && !swap_ff) begin
                  cost_ff <= alu_res[COST_BITS-1:0];
                  temp_ff <= start_temp_ff;
                  rej_ff  <= '0;
               end
            end
            ST_TAKE:   cost_ff <= sum_ff;
            ST_REJECT: rej_ff  <= rej_inc;
            ST_COOL: begin
               temp_ff <= alu_res[TEMP_BITS-1:0];
               rej_ff  <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               action_ff <= req_action;
               slot_ff   <= req_slot;
               other_ff  <= req_other_slot;
               rand_ff   <= req_random_value;
               swap_ff   <= (req_action == ACT_PROPOSE);
               idx_ff    <= '0;
               at_ff     <= src_ff;
               sum_ff    <= '0;
               acc_ff    <= 1'b0;
            end
         end
         ST_WALK_DIST: begin
            city_ff <= walk_city;
            if (idx_ff == slot_ff) begin
               city_slot_ff <= walk_city;
            end
            if (idx_ff == other_ff) begin
               city_other_ff <= walk_city;
            end
         end
         ST_WALK_ACC: begin
            sum_ff <= alu_res[COST_BITS-1:0];
            at_ff  <= city_ff;
            idx_ff <= idx_ff + SLOT_BITS'(1);
         end
         ST_DIFF: begin
            rem_ff <= ALU_BITS'(alu_res[COST_BITS-1:0]) << DIV_PRESHIFT;
            bit_ff <= X_IDX_BITS'(X_BITS-1);
         end
         ST_DIV: begin
            rem_ff <= alu_res;
            x_ff   <= {x_ff[X_BITS-2:0], alu_flag};
            // exp steps start from bit 0
            bit_ff <= (bit_ff == '0) ? '0 : bit_ff - X_IDX_BITS'(1);
            r_ff   <= R_BITS'(1) << EXP_FRAC;
         end
         ST_EXP: begin
            if (x_ff[bit_ff]) begin
               r_ff <= alu_res[R_BITS-1:0];
            end
            bit_ff <= bit_ff + X_IDX_BITS'(1);
         end
         ST_TAKE: acc_ff <= 1'b1;
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         rsp_accepted_ff <= acc_ff;
         rsp_cost_ff     <= cost_ff;
         rsp_done_ff     <= (temp_ff <= ONE_TEMP);
         rsp_city_ff     <= (action_ff == ACT_RD_SLOT && slot_ff < SLOT_BITS'(SLOTS))
                            ? tour_q_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_tour_cost = rsp_cost_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_city_out  = rsp_city_ff;

endmodule

>>> hw/rtl/ats_alu.sv
// shared arithmetic unit: saturating add, compare-subtract, division step,
// rounded exp multiply and cooling multiply; depends on ats_pkg
module ats_alu (
   input  ats_pkg::alu_op_type          op,
   input  logic [ats_pkg::ALU_BITS-1:0] a,
   input  logic [ats_pkg::ALU_BITS-1:0] b,
   output logic [ats_pkg::ALU_BITS-1:0] result,
   output logic                         flag
);
   import ats_pkg::*;

   logic [COST_BITS:0]              add_sum;
   logic [ALU_BITS-1:0]             shl;
   logic [2*R_BITS-1:0]             exp_prod;
   logic [2*R_BITS-1:0]             exp_round;
   logic [TEMP_BITS+CF_BITS-1:0]    cool_prod;

   assign add_sum   = (COST_BITS+1)'(a[COST_BITS-1:0]) + (COST_BITS+1)'(b[COST_BITS-1:0]);
   assign shl       = {a[ALU_BITS-2:0], 1'b0};
   assign exp_prod  = (2*R_BITS)'(a[R_BITS-1:0]) * (2*R_BITS)'(b[R_BITS-1:0]);
   assign exp_round = exp_prod + ((2*R_BITS)'(1) << (EXP_FRAC - 1));
   assign cool_prod = (TEMP_BITS+CF_BITS)'(a[TEMP_BITS-1:0])
                    * (TEMP_BITS+CF_BITS)'(b[CF_BITS-1:0]);

   always_comb begin
      result = '0;
      flag   = 1'b0;
      case (op)
         ALU_ADD_SAT: begin
            result = (add_sum > (COST_BITS+1)'(COST_MAX)) ? ALU_BITS'(COST_MAX)
                                                           : ALU_BITS'(add_sum);
         end
         ALU_SUB_GE: begin
            flag   = (a >= b);
            result = a - b;
         end
         ALU_DIV_STEP: begin
            flag   = (shl >= b);
            result = flag ? (shl - b) : shl;
         end
         ALU_MUL_EXP: begin
            result = ALU_BITS'(exp_round >> EXP_FRAC);
         end
         ALU_MUL_COOL: begin
            result = ALU_BITS'(cool_prod >> CF_BITS);
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/ats_checker.sv
// port-level checks of the annealing tour swap engine, bound to the top level
// depends on ats_pkg and assert_macros.svh
`include "assert_macros.svh"

module ats_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [ats_pkg::ACTION_BITS-1:0]     req_action,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_accepted,
   input logic [ats_pkg::CITY_BITS-1:0]       rsp_city_out
);
   import ats_pkg::*;

   // a stalled response stays offered
   `ATS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // every accepted request makes the engine busy in the next cycle
   `ATS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // a taken swap never carries a slot read
   `ATS_ASSERT_SAME(a_accept_no_city, clock, reset, rsp_valid && rsp_accepted,
                    rsp_city_out == '0)

   // only a proposal can be taken, so a slot write never leaves the engine
   // before its response register is loaded
   `ATS_ASSERT_NEXT(a_wr_slot_busy, clock, reset,
                    req_valid && !req_stall && req_action == ACT_WR_SLOT, req_stall)

endmodule

bind annealing_tour_swap_engine_top ats_checker u_ats_checker (.*);
